### design/dmf_pkg.sv
// Shared types and codes for the deduplicating message queue.
package dmf_pkg;

   // operation codes
   localparam logic OP_ADD = 1'b0;
   localparam logic OP_POP = 1'b1;

   // result status codes
   localparam logic [2:0] ST_ADDED     = 3'd0;
   localparam logic [2:0] ST_DUPLICATE = 3'd1;
   localparam logic [2:0] ST_FULL      = 3'd2;
   localparam logic [2:0] ST_POPPED    = 3'd3;
   localparam logic [2:0] ST_EMPTY     = 3'd4;

   localparam int unsigned CODE_W = 32;
   localparam int unsigned PARAM_W = 32;

   // one result item as handed from the sequencer to the output stage
   typedef struct packed {
      logic [2:0]         status;
      logic [CODE_W-1:0]  out_code;
      logic [PARAM_W-1:0] out_word;
      logic [PARAM_W-1:0] out_long;
   } result_type;

endpackage

### design/dmf_if.sv
// Valid/ready channel interfaces for request and response items.
interface dmf_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [31:0] message_code;
   logic [31:0] word_param;
   logic [31:0] long_param;

   modport source (output valid, operation, message_code, word_param, long_param,
                   input ready);
   modport sink (input valid, operation, message_code, word_param, long_param,
                 output ready);
endinterface

interface dmf_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [31:0] out_code;
   logic [31:0] out_word;
   logic [31:0] out_long;

   modport source (output valid, status, out_code, out_word, out_long, input ready);
   modport sink (input valid, status, out_code, out_word, out_long, output ready);
endinterface

### design/dmf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dmf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/dmf_seq.sv
// Sequencer: pointers, fill count and the shared code comparator that scans entries.
module dmf_seq
   import dmf_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16,
   localparam int PTR_W = $clog2(QUEUE_DEPTH),
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   dmf_req_if.sink                   req,
   // entry stores
   output logic                      wr_en,
   output logic [PTR_W-1:0]          wr_addr,
   output logic [CODE_W-1:0]         wr_code,
   output logic [2*PARAM_W-1:0]      wr_params,
   output logic [PTR_W-1:0]          code_rd_addr,
   output logic [PTR_W-1:0]          param_rd_addr,
   input  logic [CODE_W-1:0]         code_rd_data,
   input  logic [2*PARAM_W-1:0]      param_rd_data,
   // result handoff
   output result_type                res,
   input  logic                      out_free,
   output logic                      res_valid
);

   typedef enum logic [1:0] {IDLE, SCAN, POP_WAIT, FINISH} state_type;

   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);

   state_type           state_ff, state_in;
   logic [PTR_W-1:0]    head_ff, head_in;
   logic [PTR_W-1:0]    tail_ff, tail_in;
   logic [CNT_W-1:0]    fill_ff, fill_in;
   logic [PTR_W-1:0]    scan_slot_ff, scan_slot_in;
   logic [CNT_W-1:0]    issue_left_ff, issue_left_in;
   logic                cmp_valid_ff, cmp_valid_in;
   logic [CODE_W-1:0]   code_ff, code_in;
   logic [PARAM_W-1:0]  word_ff, word_in;
   logic [PARAM_W-1:0]  long_ff, long_in;
   result_type          res_ff, res_in;
   logic                accept;

   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] slot);
      return (slot == LAST_SLOT) ? '0 : slot + 1'b1;
   endfunction

   assign req.ready = (state_ff == IDLE);
   assign accept = req.valid && (state_ff == IDLE);

   // the scan reads the code store one slot a cycle; a pop reads the head
   assign code_rd_addr  = (state_ff == SCAN) ? scan_slot_ff : head_ff;
   assign param_rd_addr = head_ff;
   assign wr_addr       = tail_ff;

   // an add to an empty queue writes straight from the request
   assign wr_code   = (state_ff == IDLE) ? req.message_code : code_ff;
   assign wr_params = (state_ff == IDLE) ? {req.word_param, req.long_param}
                                         : {word_ff, long_ff};

   assign res       = res_ff;
   assign res_valid = (state_ff == FINISH) && out_free;

   // next-state logic
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      fill_in       = fill_ff;
      scan_slot_in  = scan_slot_ff;
      issue_left_in = issue_left_ff;
      cmp_valid_in  = 1'b0;
      code_in       = code_ff;
      word_in       = word_ff;
      long_in       = long_ff;
      res_in        = res_ff;
      wr_en         = 1'b0;

      unique case (state_ff)
         IDLE: begin
            if (accept) begin
               code_in = req.message_code;
               word_in = req.word_param;
               long_in = req.long_param;
               res_in  = '{status: ST_ADDED, out_code: '0, out_word: '0, out_long: '0};
               if (req.operation == OP_POP) begin
                  if (fill_ff == '0) begin
                     res_in.status = ST_EMPTY;
                     state_in      = FINISH;
                  end else begin
                     head_in  = next_slot(head_ff);
                     fill_in  = fill_ff - 1'b1;
                     state_in = POP_WAIT;
                  end
               end else if (fill_ff == '0) begin
                  // nothing stored: no duplicate possible
                  wr_en    = 1'b1;
                  tail_in  = next_slot(tail_ff);
                  fill_in  = fill_ff + 1'b1;
                  state_in = FINISH;
               end else begin
                  scan_slot_in  = head_ff;
                  issue_left_in = fill_ff;
                  state_in      = SCAN;
               end
            end
         end
         SCAN: begin
            // issue one read a cycle, compare the one issued last cycle
            if (issue_left_ff != '0) begin
               scan_slot_in  = next_slot(scan_slot_ff);
               issue_left_in = issue_left_ff - 1'b1;
               cmp_valid_in  = 1'b1;
            end
            if (cmp_valid_ff && (code_rd_data == code_ff)) begin
               res_in.status = ST_DUPLICATE;
               state_in      = FINISH;
            end else if (issue_left_ff == '0) begin
               if (fill_ff == FULL_COUNT) begin
                  res_in.status = ST_FULL;
               end else begin
                  wr_en         = 1'b1;
                  tail_in       = next_slot(tail_ff);
                  fill_in       = fill_ff + 1'b1;
                  res_in.status = ST_ADDED;
               end
               state_in = FINISH;
            end
         end
         POP_WAIT: begin
            res_in = '{status: ST_POPPED, out_code: code_rd_data,
                       out_word: param_rd_data[2*PARAM_W-1:PARAM_W],
                       out_long: param_rd_data[PARAM_W-1:0]};
            state_in = FINISH;
         end
         FINISH: begin
            if (out_free) begin
               state_in = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= IDLE;
         head_ff       <= '0;
         tail_ff       <= '0;
         fill_ff       <= '0;
         issue_left_ff <= '0;
         cmp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         fill_ff       <= fill_in;
         issue_left_ff <= issue_left_in;
         cmp_valid_ff  <= cmp_valid_in;
      end
      scan_slot_ff <= scan_slot_in;
      code_ff      <= code_in;
      word_ff      <= word_in;
      long_ff      <= long_in;
      res_ff       <= res_in;
   end

endmodule

### design/dedup_message_fifo.sv
// Top level of the deduplicating message queue: entry stores, sequencer, output register.
// An add scans the stored entries until one matches, or all of them when none does; an add to
// an empty queue, a pop and an empty pop need no scan. The result passes through the output
// register to the response channel; the next item may be taken while it waits there, but
// its own result stalls until taken.
// Synchronous active-high reset empties the queue and drops any pending result.
module dedup_message_fifo
   import dmf_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic      clock,
   input  logic      reset,
   dmf_req_if.sink   req_chan,
   dmf_rsp_if.source rsp_chan
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   logic                   wr_en;
   logic [PTR_W-1:0]       wr_addr;
   logic [CODE_W-1:0]      wr_code;
   logic [2*PARAM_W-1:0]   wr_params;
   logic [PTR_W-1:0]       code_rd_addr;
   logic [PTR_W-1:0]       param_rd_addr;
   logic [CODE_W-1:0]      code_rd_data;
   logic [2*PARAM_W-1:0]   param_rd_data;
   result_type             res;
   logic                   res_valid;
   logic                   out_free;
   logic                   out_valid_ff, out_valid_in;
   result_type             out_ff, out_in;

   dmf_ram #(.WIDTH(CODE_W), .DEPTH(QUEUE_DEPTH)) u_code_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_code),
      .rd_addr (code_rd_addr),
      .rd_data (code_rd_data)
   );

   dmf_ram #(.WIDTH(2*PARAM_W), .DEPTH(QUEUE_DEPTH)) u_param_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_params),
      .rd_addr (param_rd_addr),
      .rd_data (param_rd_data)
   );

   dmf_seq #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_seq (
      .clock         (clock),
      .reset         (reset),
      .req           (req_chan),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_code       (wr_code),
      .wr_params     (wr_params),
      .code_rd_addr  (code_rd_addr),
      .param_rd_addr (param_rd_addr),
      .code_rd_data  (code_rd_data),
      .param_rd_data (param_rd_data),
      .res           (res),
      .out_free      (out_free),
      .res_valid     (res_valid)
   );

   // output register: free when empty or being taken this cycle
   assign out_free = !out_valid_ff || rsp_chan.ready;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (res_valid) begin
         out_valid_in = 1'b1;
         out_in       = res;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      out_ff <= out_in;
   end

   assign rsp_chan.valid    = out_valid_ff;
   assign rsp_chan.status   = out_ff.status;
   assign rsp_chan.out_code = out_ff.out_code;
   assign rsp_chan.out_word = out_ff.out_word;
   assign rsp_chan.out_long = out_ff.out_long;

endmodule

### design/dmf_checker.sv
// Port-level assertions for the deduplicating message queue, bound to the top level.
module dmf_port_checks
   import dmf_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic [31:0] rsp_out_code,
   input logic [31:0] rsp_out_word,
   input logic [31:0] rsp_out_long
);

   // reset drops any pending result
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a waiting result is not withdrawn
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // one item at a time: the block is busy the cycle after taking one
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken on consecutive cycles");

   // only a pop carries payload
   a_zero_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_POPPED) |->
         (rsp_out_code == '0) && (rsp_out_word == '0) && (rsp_out_long == '0))
      else $error("payload on a non-pop result");

   // status codes stay within the defined set
   a_status_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= ST_EMPTY))
      else $error("undefined status code");

endmodule

bind dedup_message_fifo dmf_port_checks u_dmf_port_checks (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_status   (rsp_chan.status),
   .rsp_out_code (rsp_chan.out_code),
   .rsp_out_word (rsp_chan.out_word),
   .rsp_out_long (rsp_chan.out_long)
);

### test/dmf_checker.sv
// Monitor of both channels of the deduplicating message queue: predicts each response and compares.
module dmf_checker
   import dmf_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic clock,
   input  logic reset,
   dmf_req_if   req_mon,
   dmf_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending_count
);

   typedef struct packed {
      logic [CODE_W-1:0]  code;
      logic [PARAM_W-1:0] wparam;
      logic [PARAM_W-1:0] lparam;
   } message_type;

   // shadow of the queue contents, oldest first
   message_type stored_msgs[$];
   // responses still owed by the block, oldest first
   result_type  owed_rsps[$];
   int          mismatches = 0;

   always @(posedge clock) begin : watch
      result_type  want;
      message_type msg;
      logic        code_held;
      if (reset) begin
         stored_msgs.delete();
         owed_rsps.delete();
         fail_count    <= 0;
         pending_count <= 0;
      end else begin
         // response item against the oldest owed result
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (owed_rsps.size() == 0) begin
               $error("response item with none owed: status %0d", rsp_mon.status);
               mismatches++;
            end else begin
               want = owed_rsps[0];
               owed_rsps.delete(0);
               if (rsp_mon.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_mon.status);
                  mismatches++;
               end
               if (rsp_mon.out_code !== want.out_code) begin
                  $error("out_code: expected %h, actual %h", want.out_code, rsp_mon.out_code);
                  mismatches++;
               end
               if (rsp_mon.out_word !== want.out_word) begin
                  $error("out_word: expected %h, actual %h", want.out_word, rsp_mon.out_word);
                  mismatches++;
               end
               if (rsp_mon.out_long !== want.out_long) begin
                  $error("out_long: expected %h, actual %h", want.out_long, rsp_mon.out_long);
                  mismatches++;
               end
            end
         end

         // work out what an accepted request item must give
         if (req_mon.valid && req_mon.ready) begin
            want = '0;
            if (req_mon.operation == OP_ADD) begin
               // only the code takes part in the duplicate search
               code_held = 1'b0;
               foreach (stored_msgs[i])
                  if (stored_msgs[i].code == req_mon.message_code) code_held = 1'b1;
               if (code_held) begin
                  want.status = ST_DUPLICATE;
               end else if (stored_msgs.size() >= QUEUE_DEPTH) begin
                  want.status = ST_FULL;
               end else begin
                  msg.code   = req_mon.message_code;
                  msg.wparam = req_mon.word_param;
                  msg.lparam = req_mon.long_param;
                  stored_msgs.insert(stored_msgs.size(), msg);
                  want.status = ST_ADDED;
               end
            end else if (stored_msgs.size() == 0) begin
               want.status = ST_EMPTY;
            end else begin
               msg = stored_msgs[0];
               stored_msgs.delete(0);
               want.status   = ST_POPPED;
               want.out_code = msg.code;
               want.out_word = msg.wparam;
               want.out_long = msg.lparam;
            end
            owed_rsps.insert(owed_rsps.size(), want);
         end

         fail_count    <= mismatches;
         pending_count <= owed_rsps.size();
      end
   end

endmodule

### test/testbench.sv
// Testbench top for the deduplicating message queue: clock, reset, stimulus and verdict.
module testbench;
   import dmf_pkg::*;

   localparam int QUEUE_DEPTH = 16;
   localparam int ITEM_TOTAL  = 850;
   localparam int CALM_FROM   = 720;   // no idling on either side from here on
   localparam int HOLD_AT     = 150;   // receiver holds off once past this many items
   localparam int HOLD_CYCLES = 160;
   localparam int DRAIN_AT    = 400;   // sender waits for every response here
   localparam int TAIL_CYCLES = 30;
   localparam int POOL_SIZE   = 24;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   int          fail_count;
   int          pending_count;
   int          sent_count = 0;
   logic [31:0] code_pool[POOL_SIZE];

   dmf_req_if req_chan();
   dmf_rsp_if rsp_chan();

   dedup_message_fifo #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   dmf_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // give up if the block hangs
   initial begin
      #5_000_000;
      $display("dedup_message_fifo verification failed");
      $finish;
   end

   // mostly codes from a small pool, so duplicates turn up often
   function automatic logic [31:0] pick_code();
      if ($urandom_range(0, 9) < 6) return code_pool[$urandom_range(0, POOL_SIZE - 1)];
      return $urandom();
   endfunction

   // offer one request item, wait for it to be taken, then maybe idle
   task automatic offer_item(input logic op, input logic [31:0] code, wparam, lparam);
      req_chan.valid        <= 1'b1;
      req_chan.operation    <= op;
      req_chan.message_code <= code;
      req_chan.word_param   <= wparam;
      req_chan.long_param   <= lparam;
      do @(posedge clock); while (!req_chan.ready);
      sent_count++;
      if (sent_count < CALM_FROM && $urandom_range(0, 5) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   // response side: random stalls, one long hold-off, none near the end
   initial begin
      logic held_done;
      held_done = 1'b0;
      rsp_chan.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (!held_done && sent_count >= HOLD_AT) begin
            held_done = 1'b1;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (sent_count < CALM_FROM && $urandom_range(0, 3) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            repeat ($urandom_range(1, 25)) @(posedge clock);
         end
      end
   end

   // request side and verdict
   initial begin
      int add_bias;
      req_chan.valid        <= 1'b0;
      req_chan.operation    <= OP_ADD;
      req_chan.message_code <= '0;
      req_chan.word_param   <= '0;
      req_chan.long_param   <= '0;
      foreach (code_pool[i]) code_pool[i] = $urandom();
      code_pool[0] = '0;
      code_pool[1] = '1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // pop on empty, extremes, duplicate with other parameters
      offer_item(OP_POP, $urandom(), $urandom(), $urandom());
      offer_item(OP_ADD, '0, '0, '0);
      offer_item(OP_ADD, '0, '1, '1);
      offer_item(OP_ADD, '1, '1, '1);
      offer_item(OP_POP, '0, '0, '0);
      offer_item(OP_POP, '1, '1, '1);
      offer_item(OP_POP, $urandom(), $urandom(), $urandom());
      // fill to the brim across the index wrap, codes from all zeros to all ones
      for (int i = 0; i < QUEUE_DEPTH; i++)
         offer_item(OP_ADD, i * 32'h1111_1111, $urandom(), $urandom());
      // duplicate on a full queue wins over full, then a fresh code is refused
      offer_item(OP_ADD, 32'h2222_2222, $urandom(), $urandom());
      offer_item(OP_ADD, 32'hABCD_0123, $urandom(), $urandom());

      // random phases, each leaning towards adds or pops
      while (sent_count < ITEM_TOTAL) begin
         case ($urandom_range(0, 3))
            0: add_bias = 25;
            1: add_bias = 50;
            2: add_bias = 75;
            default: add_bias = 90;
         endcase
         for (int k = 0; k < 40 && sent_count < ITEM_TOTAL; k++) begin
            if (sent_count == DRAIN_AT) begin
               req_chan.valid <= 1'b0;
               do @(posedge clock); while (pending_count != 0);
            end
            offer_item(($urandom_range(0, 99) < add_bias) ? OP_ADD : OP_POP,
                       pick_code(), $urandom(), $urandom());
         end
      end

      // let the last responses come out
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("dedup_message_fifo verification clean");
      else
         $display("dedup_message_fifo verification failed");
      $finish;
   end

endmodule
